// File: sv/css_pkg.sv
// Shared types, constants and helpers of the character-set string scanner.
`timescale 1ns / 1ps
`default_nettype none

package css_pkg;

  localparam int CHAR_W          = 8;
  localparam int POS_W           = 13;
  localparam int CFG_IDX_W       = 2;
  localparam int MAX_LEN_DEF     = 4096;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int TABLE_DEPTH     = 1 << CHAR_W;

  localparam logic [POS_W-1:0]  DEPTH_MAX  = {POS_W{1'b1}};
  localparam logic [CHAR_W-1:0] OPEN_CHAR  = 8'h28;  // '('
  localparam logic [CHAR_W-1:0] CLOSE_CHAR = 8'h29;  // ')'

  // request kinds carried in tuser bit 0
  localparam logic REQ_SCAN  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_POS   = 2'd2;

  typedef enum logic [1:0] {
    MODE_ANY  = 2'd0,
    MODE_MANY = 2'd1,
    MODE_UPTO = 2'd2,
    MODE_BAL  = 2'd3
  } scan_mode_t;

  // packed so that bit 0 is target, bit 1 open, bit 2 close
  typedef struct packed {
    logic cls;
    logic opn;
    logic tgt;
  } members_t;

  // one classified subject beat between front and back
  typedef struct packed {
    members_t mem;
    logic     last;
    logic     empty;
  } beat_t;

  // membership of a table entry that was never written
  function automatic members_t dflt_members(input logic [CHAR_W-1:0] ch);
    members_t m;
    m     = '0;
    m.opn = (ch == OPEN_CHAR);
    m.cls = (ch == CLOSE_CHAR);
    return m;
  endfunction

endpackage

`default_nettype wire

// File: sv/css_front.sv
// Front end: accepts beats, owns the membership table, classifies subject bytes.
`timescale 1ns / 1ps
`default_nettype none

module css_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [15:0]      s_tdata,   // char_value[7:0], member_bits[10:8], zero pad
  input  wire logic [1:0]       s_tuser,   // req_type[0], no_char[1]
  input  wire logic             s_tlast,   // last_char
  output logic                  push_valid,
  input  wire logic             push_ready,
  output css_pkg::beat_t        push_beat
);

  localparam int TD = css_pkg::TABLE_DEPTH;

  logic [2:0]                  tbl_mem [TD];
  logic [TD-1:0]               tbl_vld;
  logic [2:0]                  rd_bits;
  logic                        rd_vld;
  logic                        st_valid;
  logic [css_pkg::CHAR_W-1:0]  st_char;
  logic                        st_last;
  logic                        st_empty;

  logic                        accept;
  logic                        is_write;
  logic [css_pkg::CHAR_W-1:0]  in_char;

  assign in_char  = s_tdata[css_pkg::CHAR_W-1:0];
  assign is_write = (s_tuser[0] == css_pkg::REQ_WRITE);
  assign s_tready = !st_valid || push_ready;
  assign accept   = s_tvalid && s_tready;

  // table write port and registered read port
  always_ff @(posedge clk) begin
    if (accept && is_write) begin
      tbl_mem[in_char] <= s_tdata[css_pkg::CHAR_W+2:css_pkg::CHAR_W];
    end
    if (accept && !is_write) begin
      rd_bits <= tbl_mem[in_char];
      st_char <= in_char;
      st_last <= s_tlast;
      st_empty <= s_tuser[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_vld  <= '0;
      rd_vld   <= 1'b0;
      st_valid <= 1'b0;
    end else begin
      if (accept && is_write) begin
        tbl_vld[in_char] <= 1'b1;
      end
      if (accept && !is_write) begin
        rd_vld   <= tbl_vld[in_char];
        st_valid <= 1'b1;
      end else if (push_ready) begin
        st_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    push_valid      = st_valid;
    push_beat.mem   = rd_vld ? css_pkg::members_t'(rd_bits)
                             : css_pkg::dflt_members(st_char);
    push_beat.last  = st_last;
    push_beat.empty = st_empty;
  end

endmodule

`default_nettype wire

// File: sv/css_fifo.sv
// Short queue of classified beats between front and back.
`timescale 1ns / 1ps
`default_nettype none

module css_fifo #(
  parameter int DEPTH = css_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire css_pkg::beat_t  push_beat,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output css_pkg::beat_t       pop_beat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  css_pkg::beat_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_beat   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not grow on push");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (count == '0 && wr_ptr == rd_ptr))
    else $error("queue not empty after reset");

endmodule

`default_nettype wire

// File: sv/css_back.sv
// Back end: configuration registers, scan engine and result register.
`timescale 1ns / 1ps
`default_nettype none

module css_back #(
  parameter int MAX_LEN = css_pkg::MAX_LEN_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [css_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [css_pkg::POS_W-1:0]        cfg_wdata,
  input  wire logic                             pop_valid,
  output logic                                  pop_ready,
  input  wire css_pkg::beat_t                   pop_beat,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [15:0]                           m_tdata   // success[0], result_pos[13:1]
);

  localparam int POS_W = css_pkg::POS_W;
  localparam int IDX_W = $clog2(MAX_LEN + 1);
  localparam int CMP_W = (IDX_W > POS_W) ? IDX_W : POS_W;

  css_pkg::scan_mode_t scan_mode;
  logic [POS_W-1:0]    start_pos;
  logic [POS_W-1:0]    end_pos;

  logic [IDX_W-1:0]    char_index, char_index_next;
  logic [POS_W-1:0]    nest_depth, nest_depth_next;
  logic                decided, decided_next;
  logic                held_success, held_success_next;
  logic [POS_W-1:0]    held_pos, held_pos_next;
  logic                out_success;
  logic [POS_W-1:0]    out_pos;

  logic                pop;
  logic                emit;
  logic [CMP_W-1:0]    q_c;
  logic [CMP_W-1:0]    start_c;
  logic [CMP_W-1:0]    start_eff;
  logic                in_win;
  logic                before_start;
  logic [POS_W-1:0]    pos_q;
  logic [POS_W-1:0]    pos_q1;

  assign pop_ready = !m_tvalid || m_tready;
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= css_pkg::MODE_ANY;
      start_pos <= POS_W'(1);
      end_pos   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        css_pkg::CFG_SCAN_MODE: scan_mode <= css_pkg::scan_mode_t'(cfg_wdata[1:0]);
        css_pkg::CFG_START_POS: start_pos <= cfg_wdata;
        css_pkg::CFG_END_POS:   end_pos   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // position of the byte at the head of the queue
  always_comb begin
    q_c          = CMP_W'(char_index) + 1'b1;
    start_c      = CMP_W'(start_pos);
    start_eff    = (start_pos == '0) ? CMP_W'(1) : start_c;
    in_win       = (end_pos == '0) || (q_c < CMP_W'(end_pos));
    pos_q        = POS_W'(q_c);
    pos_q1       = POS_W'(q_c + 1'b1);
    before_start = (q_c < start_eff);
  end

  always_comb begin
    char_index_next   = char_index;
    nest_depth_next   = nest_depth;
    decided_next      = decided;
    held_success_next = held_success;
    held_pos_next     = held_pos;
    emit              = 1'b0;
    if (pop) begin
      if (pop_beat.empty) begin
        emit = 1'b1;
      end else begin
        if (char_index < IDX_W'(MAX_LEN)) begin
          char_index_next = char_index + 1'b1;
          if (!decided) begin
            case (scan_mode)
              css_pkg::MODE_ANY: begin
                if (start_pos == '0) begin
                  decided_next = 1'b1;
                end else if (!before_start) begin
                  if (in_win && pop_beat.mem.tgt) begin
                    held_success_next = 1'b1;
                    held_pos_next     = pos_q1;
                  end
                  decided_next = 1'b1;
                end
              end
              css_pkg::MODE_MANY: begin
                if (start_pos == '0) begin
                  decided_next = 1'b1;
                end else if (!before_start) begin
                  // extend the run, or close it where it stands
                  if (in_win && pop_beat.mem.tgt) begin
                    held_success_next = 1'b1;
                    held_pos_next     = pos_q1;
                  end else begin
                    decided_next = 1'b1;
                  end
                end
              end
              css_pkg::MODE_UPTO: begin
                if (!before_start) begin
                  if (!in_win) begin
                    decided_next = 1'b1;
                  end else if (pop_beat.mem.tgt) begin
                    held_success_next = 1'b1;
                    held_pos_next     = pos_q;
                    decided_next      = 1'b1;
                  end
                end
              end
              default: begin
                if (!before_start) begin
                  if (!in_win) begin
                    decided_next = 1'b1;
                  end else if (pop_beat.mem.opn) begin
                    if (nest_depth < css_pkg::DEPTH_MAX) begin
                      nest_depth_next = nest_depth + 1'b1;
                    end
                  end else if (pop_beat.mem.cls && nest_depth != '0) begin
                    nest_depth_next = nest_depth - 1'b1;
                  end else if (nest_depth == '0 && pop_beat.mem.tgt) begin
                    // unmatched close falls through to here
                    held_success_next = 1'b1;
                    held_pos_next     = pos_q;
                    decided_next      = 1'b1;
                  end
                end
              end
            endcase
          end
        end
        emit = pop_beat.last;
      end
    end
    out_success = held_success_next;
    out_pos     = held_success_next ? held_pos_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_index   <= '0;
      nest_depth   <= '0;
      decided      <= 1'b0;
      held_success <= 1'b0;
      held_pos     <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (emit) begin
        char_index   <= '0;
        nest_depth   <= '0;
        decided      <= 1'b0;
        held_success <= 1'b0;
        held_pos     <= '0;
      end else begin
        char_index   <= char_index_next;
        nest_depth   <= nest_depth_next;
        decided      <= decided_next;
        held_success <= held_success_next;
        held_pos     <= held_pos_next;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {2'b00, out_pos, out_success};
    end
  end

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    char_index <= IDX_W'(MAX_LEN))
    else $error("char index above maximum length");

  a_empty_emits: assert property (@(posedge clk) disable iff (rst)
    (pop && pop_beat.empty) |=> (m_tvalid && char_index == '0 && !decided))
    else $error("empty subject gave no result");

  a_fail_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[POS_W:1] == '0))
    else $error("failed scan carries a position");

endmodule

`default_nettype wire

// File: sv/cset_string_scanner_unit.sv
// Top level of the character-set string scanner.
`timescale 1ns / 1ps
`default_nettype none

// Runs one of the any, many, upto or balanced scans over a subject that
// streams in one byte per beat, and returns one result beat (success and
// one-based position) on the beat marked tlast or on an empty-subject beat.
// Beats with tuser[0] set load one entry of the 256-entry membership table
// (target, open, close) and give no result; later bytes see the new entry.
// The block takes one beat per cycle while the result side keeps up; a
// stalled result side fills the queue and then drops s_tready. A result
// passes the registered table read in the front end, the beat queue, and
// the scan engine that updates position, depth and outcome. The queue lets
// the front keep taking beats while the result side is stalled, until full.
// Configuration writes take effect at once and are meant for idle periods.

module cset_string_scanner_unit #(
  parameter int MAX_LEN     = css_pkg::MAX_LEN_DEF,
  parameter int QUEUE_DEPTH = css_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [css_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [css_pkg::POS_W-1:0]      cfg_wdata,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [15:0]                    s_tdata,   // char_value[7:0], member_bits[10:8]
  input  wire logic [1:0]                     s_tuser,   // req_type[0], no_char[1]
  input  wire logic                           s_tlast,   // last_char
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [15:0]                         m_tdata    // success[0], result_pos[13:1]
);

  logic           push_valid;
  logic           push_ready;
  css_pkg::beat_t push_beat;
  logic           pop_valid;
  logic           pop_ready;
  css_pkg::beat_t pop_beat;

  css_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_beat  (push_beat)
  );

  css_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_beat  (push_beat),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_beat   (pop_beat)
  );

  css_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_beat  (pop_beat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire
